@@ hw/rtl/htw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_pkg: shared types and constants of the hierarchical timer wheel
// Payload structs, cell control bundle and sizing constants.
// ----------------------------------------------------------------------------
package htw_pkg;

   localparam int NUM_TIMERS = 32;
   localparam int TIME_W     = 32;
   localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int RANK_LAST  = NUM_TIMERS - 2;

   localparam logic [1:0] MODE_START   = 2'd0;
   localparam logic [1:0] MODE_STOP    = 2'd1;
   localparam logic [1:0] MODE_ADVANCE = 2'd2;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_FIRED = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   typedef struct packed {
      logic [1:0]        mode;
      logic [4:0]        timer_id;
      logic [TIME_W-1:0] time_value;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] fired_or_target_id;
      logic       flag;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_ARM,
      CELL_DISARM,
      CELL_CLEAR,
      CELL_LOAD,
      CELL_RANK,
      CELL_EMIT
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [IDX_W-1:0]  tgt;
      logic [TIME_W-1:0] expiry;
      logic [TIME_W-1:0] cur;
      logic [TIME_W-1:0] span;
      logic [CNT_W-1:0]  slot;
   } cell_ctrl_type;

   // sort key handed around the ring
   typedef struct packed {
      logic [TIME_W-1:0] off;
      logic [IDX_W-1:0]  id;
      logic              qual;
   } cell_key_type;

endpackage

@@ hw/rtl/hierarchical_timer_wheel_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_core: timer bank with a running tick
// A start or stop command is taken while idle and acknowledged in the next
// cycle. An advance that lands in the past answers with a single done result
// in the cycle after the transfer. An advance that runs keeps busy high
// through a load state, a rank state in which the cells pass their due
// offsets around the ring to rank themselves, then an emit state that gives
// one fired result per cycle in expiry order (lowest timer number first on
// equal expiry) and a final done result. Results appear on rsp_data for
// exactly one cycle with rsp_strobe; the receiver cannot hold them off. A
// csr_we write clears all timers and loads the tick; issue it only while the
// block is idle.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  htw_pkg::req_type              req_data,
   output logic                          rsp_strobe,
   output htw_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [htw_pkg::TIME_W-1:0]    csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RANK,
      ST_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [htw_pkg::TIME_W-1:0] cur_ff, cur_in;
   logic [htw_pkg::TIME_W-1:0] tv_ff, tv_in;
   logic [htw_pkg::TIME_W-1:0] span_ff, span_in;
   logic [htw_pkg::IDX_W-1:0]  step_ff, step_in;
   logic [htw_pkg::CNT_W-1:0]  slot_ff, slot_in;
   logic                       strobe_ff, strobe_in;
   htw_pkg::rsp_type           rsp_ff, rsp_in;

   htw_pkg::cell_ctrl_type     ctrl;
   htw_pkg::cell_key_type      cell_pass [htw_pkg::NUM_TIMERS];
   logic [htw_pkg::NUM_TIMERS-1:0] pend_vec;
   logic [htw_pkg::NUM_TIMERS-1:0] hit_vec;

   logic                       accept;
   logic                       in_range;
   logic [htw_pkg::TIME_W-1:0] delta;
   logic [htw_pkg::IDX_W-1:0]  fire_id;
   logic                       any_hit;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;
   assign in_range   = (7'(req_data.timer_id) < 7'(htw_pkg::NUM_TIMERS));
   assign delta      = req_data.time_value - cur_ff;

   always_comb begin
      fire_id = '0;
      for (int j = 0; j < htw_pkg::NUM_TIMERS; j++) begin
         if (hit_vec[j]) begin
            fire_id = fire_id | htw_pkg::IDX_W'(j);
         end
      end
   end

   assign any_hit = |hit_vec;

   genvar g;
   generate
      for (g = 0; g < htw_pkg::NUM_TIMERS; g++) begin : g_cell
         htw_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .my_idx   (htw_pkg::IDX_W'(g)),
            .ctrl     (ctrl),
            .pass_in  (cell_pass[(g + htw_pkg::NUM_TIMERS - 1) % htw_pkg::NUM_TIMERS]),
            .pass_out (cell_pass[g]),
            .pending  (pend_vec[g]),
            .hit      (hit_vec[g])
         );
      end
   endgenerate

   // cell control depends on state, request, csr_we, tick, span and slot
   always_comb begin
      ctrl.op     = htw_pkg::CELL_HOLD;
      ctrl.tgt    = htw_pkg::IDX_W'(req_data.timer_id);
      ctrl.expiry = delta[htw_pkg::TIME_W-1] ? cur_ff : req_data.time_value;
      ctrl.cur    = cur_ff;
      ctrl.span   = span_ff;
      ctrl.slot   = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               ctrl.op = htw_pkg::CELL_CLEAR;
            end else if (accept && in_range) begin
               if (req_data.mode == htw_pkg::MODE_START) begin
                  ctrl.op = htw_pkg::CELL_ARM;
               end else if (req_data.mode == htw_pkg::MODE_STOP) begin
                  ctrl.op = htw_pkg::CELL_DISARM;
               end
            end
         end
         ST_LOAD: begin
            ctrl.op = htw_pkg::CELL_LOAD;
         end
         ST_RANK: begin
            ctrl.op = htw_pkg::CELL_RANK;
         end
         ST_EMIT: begin
            ctrl.op = htw_pkg::CELL_EMIT;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      tv_in       = tv_ff;
      span_in     = span_ff;
      step_in     = step_ff;
      slot_in     = slot_ff;
      strobe_in   = 1'b0;
      rsp_in      = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               cur_in  = csr_wdata;
            end else if (accept) begin
               if (req_data.mode == htw_pkg::MODE_START ||
                   req_data.mode == htw_pkg::MODE_STOP) begin
                  strobe_in                 = 1'b1;
                  rsp_in.kind               = htw_pkg::KIND_ACK;
                  rsp_in.fired_or_target_id = req_data.timer_id;
                  rsp_in.flag               = in_range && pend_vec[ctrl.tgt];
                  rsp_in.last               = 1'b1;
               end else if (req_data.mode == htw_pkg::MODE_ADVANCE) begin
                  if (delta[htw_pkg::TIME_W-1]) begin
                     strobe_in                 = 1'b1;
                     rsp_in.kind               = htw_pkg::KIND_DONE;
                     rsp_in.fired_or_target_id = '0;
                     rsp_in.flag               = 1'b0;
                     rsp_in.last               = 1'b1;
                  end else begin
                     tv_in    = req_data.time_value;
                     span_in  = delta;
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_LOAD: begin
            step_in  = '0;
            slot_in  = '0;
            state_in = (htw_pkg::NUM_TIMERS > 1) ? ST_RANK : ST_EMIT;
         end
         ST_RANK: begin
            step_in = step_ff + 1'b1;
            if (step_ff == htw_pkg::IDX_W'(htw_pkg::RANK_LAST)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            strobe_in = 1'b1;
            if (any_hit) begin
               rsp_in.kind               = htw_pkg::KIND_FIRED;
               rsp_in.fired_or_target_id = 5'(fire_id);
               rsp_in.flag               = 1'b0;
               rsp_in.last               = 1'b0;
               slot_in                   = slot_ff + 1'b1;
            end else begin
               rsp_in.kind               = htw_pkg::KIND_DONE;
               rsp_in.fired_or_target_id = '0;
               rsp_in.flag               = 1'b1;
               rsp_in.last               = 1'b1;
               cur_in                    = tv_ff + 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cur_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cur_ff    <= cur_in;
         strobe_ff <= strobe_in;
      end
      tv_ff   <= tv_in;
      span_ff <= span_in;
      step_ff <= step_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

endmodule

@@ hw/rtl/htw_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_cell: one timer slot of the wheel
// Holds expiry and pending bit, ranks its due offset against the keys that
// rotate through the ring, and reports a hit when its rank is called.
// ----------------------------------------------------------------------------
module htw_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [htw_pkg::IDX_W-1:0]    my_idx,
   input  htw_pkg::cell_ctrl_type       ctrl,
   input  htw_pkg::cell_key_type        pass_in,
   output htw_pkg::cell_key_type        pass_out,
   output logic                         pending,
   output logic                         hit
);

   logic [htw_pkg::TIME_W-1:0] exp_ff, exp_in;
   logic                       pend_ff, pend_in;
   htw_pkg::cell_key_type      own_ff, own_in;
   htw_pkg::cell_key_type      pass_ff, pass_in_nxt;
   logic [htw_pkg::IDX_W-1:0]  rank_ff, rank_in;
   logic                       sel;
   logic                       beats;
   logic [htw_pkg::TIME_W-1:0] off;

   assign sel      = (ctrl.tgt == my_idx);
   assign off      = exp_ff - ctrl.cur;
   assign pass_out = pass_ff;
   assign pending  = pend_ff;

   assign beats = pass_in.qual &&
                  ((pass_in.off < own_ff.off) ||
                   ((pass_in.off == own_ff.off) && (pass_in.id < own_ff.id)));

   assign hit = (ctrl.op == htw_pkg::CELL_EMIT) && own_ff.qual &&
                (htw_pkg::CNT_W'(rank_ff) == ctrl.slot);

   always_comb begin
      exp_in      = exp_ff;
      pend_in     = pend_ff;
      own_in      = own_ff;
      pass_in_nxt = pass_ff;
      rank_in     = rank_ff;
      case (ctrl.op)
         htw_pkg::CELL_ARM: begin
            if (sel) begin
               exp_in  = ctrl.expiry;
               pend_in = 1'b1;
            end
         end
         htw_pkg::CELL_DISARM: begin
            if (sel) begin
               pend_in = 1'b0;
            end
         end
         htw_pkg::CELL_CLEAR: begin
            pend_in = 1'b0;
         end
         htw_pkg::CELL_LOAD: begin
            own_in.off  = off;
            own_in.id   = my_idx;
            own_in.qual = pend_ff && (off <= ctrl.span);
            pass_in_nxt = own_in;
            rank_in     = '0;
         end
         htw_pkg::CELL_RANK: begin
            pass_in_nxt = pass_in;
            if (beats) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         htw_pkg::CELL_EMIT: begin
            if (hit) begin
               pend_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      exp_ff  <= exp_in;
      own_ff  <= own_in;
      pass_ff <= pass_in_nxt;
      rank_ff <= rank_in;
   end

endmodule

@@ dv/hierarchical_timer_wheel_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_core_tb: self-checking bench for the timer wheel
// Drives start/stop/advance commands through the start/busy handshake and
// tick loads through the CSR port. A local wheel model computes the owed
// acks, firings and done results, which are checked field by field in order.
// Directed tests cover ack flags, past and half-range expiries, wrap and tie
// order; random traffic with sender gaps runs under several tick loads.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_core_tb;
   import htw_pkg::*;

   localparam logic [1:0] MODE_UNUSED    = 2'd3;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         SETTLE_CYCLES  = NUM_TIMERS + 8;
   localparam int         PHASE_ITEMS    = 64;
   localparam int         MAX_PRINTS     = 40;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   logic              busy;
   req_type           req_data  = '0;
   logic              rsp_strobe;
   rsp_type           rsp_data;
   logic              csr_we    = 1'b0;
   logic [TIME_W-1:0] csr_wdata = '0;

   // wheel model state
   logic [TIME_W-1:0]     wheel_tick;
   logic [TIME_W-1:0]     wheel_expiry [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] wheel_armed;
   rsp_type               rsp_owed [$];

   // stimulus-side view of the tick, used only to shape values
   logic [TIME_W-1:0] stim_tick = '0;
   bit                gaps_on   = 1'b1;

   int err_count   = 0;
   int cmd_count   = 0;
   int rsp_count   = 0;
   int fire_count  = 0;
   int load_count  = 0;
   int quiet_count = 0;

   hierarchical_timer_wheel_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic flag_error(input string msg);
      err_count++;
      if (err_count <= MAX_PRINTS)
         $display("%0t ERROR: %s", $time, msg);
   endtask

   function automatic void push_rsp(input logic [1:0] kind, input logic [4:0] id,
                                    input logic flag, input logic last);
      rsp_type o;
      o.kind               = kind;
      o.fired_or_target_id = id;
      o.flag               = flag;
      o.last               = last;
      rsp_owed.push_back(o);
   endfunction

   function automatic void wheel_step(input req_type r);
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] off;
      logic [TIME_W-1:0] best_off;
      int                best;
      int                i;
      span = r.time_value - wheel_tick;
      case (r.mode)
         MODE_START, MODE_STOP: begin
            if (int'(r.timer_id) >= NUM_TIMERS) begin
               push_rsp(KIND_ACK, r.timer_id, 1'b0, 1'b1);
            end else begin
               push_rsp(KIND_ACK, r.timer_id, wheel_armed[r.timer_id], 1'b1);
               if (r.mode == MODE_START) begin
                  // half range or more ahead counts as already due
                  wheel_expiry[r.timer_id] = span[TIME_W-1] ? wheel_tick : r.time_value;
                  wheel_armed[r.timer_id]  = 1'b1;
               end else begin
                  wheel_armed[r.timer_id] = 1'b0;
               end
            end
         end
         MODE_ADVANCE: begin
            if (span[TIME_W-1]) begin
               push_rsp(KIND_DONE, '0, 1'b0, 1'b1);
            end else begin
               do begin
                  best     = -1;
                  best_off = '0;
                  for (i = 0; i < NUM_TIMERS; i++) begin
                     if (wheel_armed[i]) begin
                        off = wheel_expiry[i] - wheel_tick;
                        if (off <= span && (best < 0 || off < best_off)) begin
                           best     = i;
                           best_off = off;
                        end
                     end
                  end
                  if (best >= 0) begin
                     wheel_armed[best] = 1'b0;
                     push_rsp(KIND_FIRED, best[4:0], 1'b0, 1'b0);
                  end
               end while (best >= 0);
               wheel_tick = r.time_value + 1'b1;
               push_rsp(KIND_DONE, '0, 1'b1, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   // transfer monitor: predicts on accepted commands, checks every result
   always @(posedge clock) begin : monitor
      rsp_type owed;
      logic    took;
      took = start && (busy === 1'b0) && !reset;
      if (reset) begin
         wheel_tick  = '0;
         wheel_armed = '0;
      end else if (csr_we) begin
         wheel_armed = '0;
         wheel_tick  = csr_wdata;
      end
      if (rsp_strobe === 1'b1 && !reset) begin
         rsp_count++;
         if (rsp_owed.size() == 0) begin
            flag_error($sformatf("unexpected result kind %0d id %0d flag %0d last %0d",
                                 rsp_data.kind, rsp_data.fired_or_target_id,
                                 rsp_data.flag, rsp_data.last));
         end else begin
            owed = rsp_owed.pop_front();
            if (owed.kind == KIND_FIRED)
               fire_count++;
            if (rsp_data.kind !== owed.kind)
               flag_error($sformatf("kind got %0d want %0d", rsp_data.kind, owed.kind));
            if (rsp_data.fired_or_target_id !== owed.fired_or_target_id)
               flag_error($sformatf("id got %0d want %0d", rsp_data.fired_or_target_id,
                                    owed.fired_or_target_id));
            if (rsp_data.flag !== owed.flag)
               flag_error($sformatf("flag got %0d want %0d (id %0d)", rsp_data.flag,
                                    owed.flag, owed.fired_or_target_id));
            if (rsp_data.last !== owed.last)
               flag_error($sformatf("last got %0d want %0d", rsp_data.last, owed.last));
         end
      end
      if (took) begin
         cmd_count++;
         wheel_step(req_data);
      end
      if (took || rsp_strobe === 1'b1)
         quiet_count = 0;
      else
         quiet_count++;
      if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic issue_cmd(input logic [1:0] mode, input logic [4:0] id,
                            input logic [TIME_W-1:0] tv);
      req_type           r;
      logic [TIME_W-1:0] span;
      r.mode       = mode;
      r.timer_id   = id;
      r.time_value = tv;
      span         = tv - stim_tick;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      if (mode == MODE_ADVANCE && !span[TIME_W-1])
         stim_tick = tv + 1'b1;
   endtask

   task automatic sender_gap();
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (rsp_owed.size() != 0);
      @(posedge clock);
   endtask

   task automatic load_tick(input logic [TIME_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      stim_tick = value;
      load_count++;
   endtask

   task automatic cmd_gap(input logic [1:0] mode, input logic [4:0] id,
                          input logic [TIME_W-1:0] tv);
      issue_cmd(mode, id, tv);
      sender_gap();
   endtask

   task automatic test_ack_flags();
      load_tick(32'h0000_0000);
      cmd_gap(MODE_START, 5'd0, 32'd5);
      cmd_gap(MODE_START, 5'd31, 32'd5);
      cmd_gap(MODE_START, 5'd0, 32'd9);
      cmd_gap(MODE_STOP, 5'd31, 32'hffff_ffff);
      cmd_gap(MODE_STOP, 5'd31, 32'h0000_0000);
      cmd_gap(MODE_UNUSED, 5'd31, 32'hffff_ffff);
      cmd_gap(MODE_START, 5'd21, 32'd3);
      cmd_gap(MODE_ADVANCE, 5'd0, 32'd9);
   endtask

   task automatic test_expiry_edges();
      load_tick(32'h8000_0000);
      cmd_gap(MODE_START, 5'd7, 32'h7fff_ffff);
      cmd_gap(MODE_START, 5'd12, 32'h0000_0000);
      cmd_gap(MODE_START, 5'd3, 32'h8000_0000);
      cmd_gap(MODE_START, 5'd20, 32'hffff_ffff);
      cmd_gap(MODE_ADVANCE, 5'd0, 32'h7fff_ffff);
      cmd_gap(MODE_ADVANCE, 5'd0, 32'h8000_0000);
      cmd_gap(MODE_ADVANCE, 5'd0, 32'hffff_ffff);
      cmd_gap(MODE_STOP, 5'd20, 32'h5555_5555);
      cmd_gap(MODE_ADVANCE, 5'd0, 32'h7fff_ffff);
   endtask

   task automatic test_tick_wrap();
      load_tick(32'hffff_fff0);
      cmd_gap(MODE_START, 5'd4, 32'hffff_fffa);
      cmd_gap(MODE_START, 5'd9, 32'h0000_0002);
      cmd_gap(MODE_START, 5'd2, 32'h0000_0002);
      cmd_gap(MODE_ADVANCE, 5'd31, 32'h0000_0010);
   endtask

   // arms every timer near the tick, then one advance fires them all
   task automatic arm_all_and_fire();
      int rot;
      int i;
      rot = $urandom_range(0, NUM_TIMERS - 1);
      for (i = 0; i < NUM_TIMERS; i++)
         cmd_gap(MODE_START, 5'((i * 7 + rot) % NUM_TIMERS),
                 stim_tick + $urandom_range(0, 12));
      cmd_gap(MODE_ADVANCE, 5'($urandom()), stim_tick + 12);
   endtask

   task automatic random_cmd();
      int                pick;
      logic [4:0]        id;
      logic [TIME_W-1:0] tv;
      pick = $urandom_range(0, 99);
      id   = 5'($urandom_range(0, 31));
      if (pick < 45) begin
         case ($urandom_range(0, 9))
            0:       tv = $urandom();
            1:       tv = stim_tick - $urandom_range(1, 1000);
            default: tv = stim_tick + $urandom_range(0, 48);
         endcase
         cmd_gap(MODE_START, id, tv);
      end else if (pick < 62) begin
         cmd_gap(MODE_STOP, id, $urandom());
      end else if (pick < 96) begin
         case ($urandom_range(0, 9))
            0:       tv = $urandom();
            1:       tv = stim_tick - $urandom_range(1, 64);
            default: tv = stim_tick + $urandom_range(0, 20);
         endcase
         cmd_gap(MODE_ADVANCE, id, tv);
      end else begin
         cmd_gap(MODE_UNUSED, id, $urandom());
      end
   endtask

   task automatic test_random_traffic();
      logic [TIME_W-1:0] loads [6];
      int                p;
      int                sent;
      loads[0] = 32'hffff_ffff;
      loads[1] = 32'h7fff_ffff;
      loads[2] = $urandom();
      loads[3] = 32'h0000_0000;
      loads[4] = $urandom();
      loads[5] = $urandom();
      for (p = 0; p < 6; p++) begin
         load_tick(loads[p]);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (sent % 16 == 0)
               gaps_on = (p != 5) && ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 39) == 0) begin
               arm_all_and_fire();
               sent += NUM_TIMERS + 1;
            end else begin
               random_cmd();
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_ack_flags();
      test_expiry_edges();
      test_tick_wrap();
      test_random_traffic();
      wait_drained();
      repeat (2 * NUM_TIMERS + 8) @(posedge clock);
      $display("covered %0d commands and %0d results, %0d of them timer firings,",
               cmd_count, rsp_count, fire_count);
      $display("across %0d tick loads; %0d mismatches", load_count, err_count);
      if (err_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
